@@ rtl/core/ymr_pkg.sv @@
`default_nettype none
package ymr_pkg;

    localparam int unsigned SHORT_DATA     = 128;
    localparam int unsigned LONG_DATA      = 1024;
    localparam int unsigned FRAME_OVERHEAD = 5;
    localparam int unsigned NAME_LIMIT     = 64;
    localparam int unsigned SIZE_DIGITS    = 16;
    localparam int unsigned HDR_BYTES      = 3;
    localparam int unsigned MAX_RES        = 3;

    localparam logic [7:0] C_SOH = 8'h01;
    localparam logic [7:0] C_STX = 8'h02;
    localparam logic [7:0] C_EOT = 8'h04;
    localparam logic [7:0] C_ACK = 8'h06;
    localparam logic [7:0] C_NAK = 8'h15;
    localparam logic [7:0] C_CAN = 8'h18;
    localparam logic [7:0] C_SPC = 8'h20;
    localparam logic [7:0] SAT8  = 8'hff;

    localparam logic [1:0] K_REPLY  = 2'd0;
    localparam logic [1:0] K_WRITE  = 2'd1;
    localparam logic [1:0] K_NAME   = 2'd2;
    localparam logic [1:0] K_FINISH = 2'd3;

    localparam logic [2:0] ST_NONE    = 3'd0;
    localparam logic [2:0] ST_DONE    = 3'd1;
    localparam logic [2:0] ST_ABORT   = 3'd2;
    localparam logic [2:0] ST_ERRORS  = 3'd3;
    localparam logic [2:0] ST_TOOLARGE = 3'd4;

    localparam logic [2:0] REG_INIT_TO  = 3'd0;
    localparam logic [2:0] REG_RETRY_TO = 3'd1;
    localparam logic [2:0] REG_MAX_ERR  = 3'd2;
    localparam logic [2:0] REG_EXTRA    = 3'd3;
    localparam logic [2:0] REG_BUF_LEN  = 3'd4;

    localparam logic [2:0] CV_START = 3'd0;
    localparam logic [2:0] CV_ZERO  = 3'd1;
    localparam logic [2:0] CV_PFX   = 3'd2;
    localparam logic [2:0] CV_DEC   = 3'd3;
    localparam logic [2:0] CV_OCT   = 3'd4;
    localparam logic [2:0] CV_HEX   = 3'd5;
    localparam logic [2:0] CV_STOP  = 3'd6;

    typedef enum logic [1:0] {
        PH_START,
        PH_CAN2,
        PH_PACKET,
        PH_IDLE
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_value;
        logic [23:0] address;
        logic [2:0]  status;
        logic [31:0] fsize;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res [2:0] res;
    } t_step;

    function automatic t_res f_res(logic [1:0] kind, logic [7:0] val, logic [23:0] addr,
                                   logic [2:0] st, logic [31:0] size);
        t_res r;
        r.kind       = kind;
        r.byte_value = val;
        r.address    = addr;
        r.status     = st;
        r.fsize      = size;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/ymr_core.sv @@
`default_nettype none
module ymr_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [2:0]     i_cfg_index,
    input  wire logic [23:0]    i_cfg_data,
    input  wire logic           i_take,
    input  wire logic           i_mode,
    input  wire logic [7:0]     i_rx_byte,
    output ymr_pkg::t_step      o_step
);

    logic [23:0] r_init_to, r_retry_to, r_buf_len;
    logic [7:0]  r_max_err, r_extra;

    ymr_pkg::t_phase r_phase, n_phase;
    logic [10:0] r_pos, n_pos;
    logic        r_long, n_long;
    logic [7:0]  r_seq, n_seq;
    logic        r_taken, n_taken;
    logic [7:0]  r_err, n_err;
    logic        r_use_retry, n_use_retry;
    logic [23:0] r_ticks, n_ticks;
    logic [23:0] r_woff, n_woff;
    logic [31:0] r_size, n_size;
    logic [7:0]  r_hf, n_hf;
    logic [7:0]  r_ndi, n_ndi;

    ymr_pkg::t_res [2:0] es;
    logic [1:0]  cnt;
    logic [23:0] tlimit;
    logic [24:0] tnext;
    logic [8:0]  elimit;
    logic [7:0]  ecount;
    logic [10:0] psize, total;
    logic [9:0]  dofs;
    logic [24:0] wend;
    logic [7:0]  b;
    logic [2:0]  cst;
    logic [4:0]  dv;
    logic [4:0]  base;
    logic [35:0] acc;
    logic [2:0]  fin_st;
    logic [31:0] fin_size;
    logic        do_cancel, do_finish, do_abort;
    logic [1:0]  sub;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_to  <= 24'hffffff;
            r_retry_to <= 24'h00ffff;
            r_max_err  <= 8'd5;
            r_extra    <= 8'd30;
            r_buf_len  <= 24'hffffff;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ymr_pkg::REG_INIT_TO:  r_init_to  <= i_cfg_data;
                ymr_pkg::REG_RETRY_TO: r_retry_to <= i_cfg_data;
                ymr_pkg::REG_MAX_ERR:  r_max_err  <= i_cfg_data[7:0];
                ymr_pkg::REG_EXTRA:    r_extra    <= i_cfg_data[7:0];
                ymr_pkg::REG_BUF_LEN:  r_buf_len  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ymr_pkg::PH_START;
            r_pos       <= '0;
            r_long      <= 1'b0;
            r_seq       <= '0;
            r_taken     <= 1'b0;
            r_err       <= '0;
            r_use_retry <= 1'b0;
            r_ticks     <= '0;
            r_woff      <= '0;
            r_size      <= '0;
            r_hf        <= '0;
            r_ndi       <= '0;
        end else begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_long      <= n_long;
            r_seq       <= n_seq;
            r_taken     <= n_taken;
            r_err       <= n_err;
            r_use_retry <= n_use_retry;
            r_ticks     <= n_ticks;
            r_woff      <= n_woff;
            r_size      <= n_size;
            r_hf        <= n_hf;
            r_ndi       <= n_ndi;
        end
    end

    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_long = r_long; n_seq = r_seq;
        n_taken = r_taken; n_err = r_err; n_use_retry = r_use_retry;
        n_ticks = r_ticks; n_woff = r_woff; n_size = r_size; n_hf = r_hf; n_ndi = r_ndi;
        es = '0;
        cnt = 2'd0;
        b = i_rx_byte;
        tlimit = r_use_retry ? r_retry_to : r_init_to;
        tnext = {1'b0, r_ticks} + 25'd1;
        elimit = (r_taken ? 9'd0 : {1'b0, r_extra}) + {1'b0, r_max_err};
        if (elimit > 9'd255) elimit = 9'd255;
        ecount = (r_err != ymr_pkg::SAT8) ? r_err + 8'd1 : r_err;
        psize = r_long ? 11'(ymr_pkg::LONG_DATA) : 11'(ymr_pkg::SHORT_DATA);
        total = psize + 11'(ymr_pkg::FRAME_OVERHEAD);
        dofs = 10'(r_pos - 11'(ymr_pkg::HDR_BYTES));
        wend = {1'b0, r_woff} + {14'd0, psize};
        cst = ymr_pkg::CV_START; dv = 5'd16; base = 5'd10; acc = '0;
        sub = 2'd0;
        do_cancel = 1'b0; do_finish = 1'b0; do_abort = 1'b0;
        fin_st = ymr_pkg::ST_NONE; fin_size = '0;

        if (i_take && r_phase != ymr_pkg::PH_IDLE) begin
            if (i_mode) begin
                if (tnext < {1'b0, tlimit}) begin
                    n_ticks = tnext[23:0];
                end else begin
                    n_ticks = '0;
                    if (r_phase == ymr_pkg::PH_CAN2) begin
                        do_abort = 1'b1;
                    end else begin
                        n_err = ecount;
                        n_phase = ymr_pkg::PH_START;
                        if ({1'b0, ecount} >= elimit) begin
                            do_cancel = 1'b1;
                            fin_st = ymr_pkg::ST_ERRORS;
                        end else begin
                            if (!r_taken) n_use_retry = 1'b1;
                            es[cnt] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_NAK,
                                                     '0, '0, '0);
                            cnt = cnt + 2'd1;
                        end
                    end
                end
            end else begin
                n_ticks = '0;
                if (r_phase == ymr_pkg::PH_CAN2) begin
                    do_abort = 1'b1;
                end else if (r_phase == ymr_pkg::PH_PACKET) begin
                    if (r_pos == 11'd1) begin
                        if (b == r_seq) n_hf[7] = 1'b1;
                    end else if (r_pos >= 11'(ymr_pkg::HDR_BYTES) &&
                                 r_pos < 11'(ymr_pkg::HDR_BYTES) + psize && r_hf[7]) begin
                        if (r_taken) begin
                            if (wend <= {1'b0, r_buf_len}) begin
                                es[cnt] = ymr_pkg::f_res(ymr_pkg::K_WRITE, b,
                                                         r_woff + {14'd0, dofs}, '0, '0);
                                cnt = cnt + 2'd1;
                            end
                        end else begin
                            // Filename packet: a non-zero byte among the first four
                            // marks the packet as a real header.
                            if (dofs < 10'd4 && b != 8'd0 && !n_hf[5]) begin
                                n_hf[5] = 1'b1;
                                n_size = '0;
                                if (n_hf[6]) begin
                                    es[cnt] = ymr_pkg::f_res(ymr_pkg::K_NAME, 8'd0,
                                                             '0, '0, '0);
                                    cnt = cnt + 2'd1;
                                end
                            end
                            sub = n_hf[1:0];
                            if (sub == 2'd0) begin
                                if (r_ndi >= 8'(ymr_pkg::NAME_LIMIT) || b == 8'd0) begin
                                    if (dofs == 10'd0 && b == 8'd0) begin
                                        n_hf[6] = 1'b1;
                                    end else begin
                                        es[cnt] = ymr_pkg::f_res(ymr_pkg::K_NAME, 8'd0,
                                                                 {16'd0, r_ndi}, '0, '0);
                                        cnt = cnt + 2'd1;
                                    end
                                    n_hf[1:0] = 2'd1;
                                    n_ndi = '0;
                                end else begin
                                    es[cnt] = ymr_pkg::f_res(ymr_pkg::K_NAME, b,
                                                             {16'd0, r_ndi}, '0, '0);
                                    cnt = cnt + 2'd1;
                                    n_ndi = r_ndi + 8'd1;
                                end
                            end else if (sub == 2'd1) begin
                                if (b == ymr_pkg::C_SPC ||
                                    r_ndi >= 8'(ymr_pkg::SIZE_DIGITS)) begin
                                    n_hf[1:0] = 2'd2;
                                end else begin
                                    n_ndi = r_ndi + 8'd1;
                                    if (n_hf[5]) begin
                                        cst = n_hf[4:2];
                                        if (b >= "0" && b <= "9") dv = 5'(b - "0");
                                        else if (b >= "a" && b <= "f") dv = 5'(b - "a" + 8'd10);
                                        else if (b >= "A" && b <= "F") dv = 5'(b - "A" + 8'd10);
                                        case (cst)
                                            ymr_pkg::CV_START: begin
                                                if (b == "0") cst = ymr_pkg::CV_ZERO;
                                                else if (dv >= 5'd1 && dv <= 5'd9) begin
                                                    n_size = {27'd0, dv};
                                                    cst = ymr_pkg::CV_DEC;
                                                end else cst = ymr_pkg::CV_STOP;
                                            end
                                            ymr_pkg::CV_ZERO: begin
                                                if (b == "x" || b == "X") cst = ymr_pkg::CV_PFX;
                                                else if (dv < 5'd8) begin
                                                    n_size = {27'd0, dv};
                                                    cst = ymr_pkg::CV_OCT;
                                                end else cst = ymr_pkg::CV_STOP;
                                            end
                                            ymr_pkg::CV_PFX: begin
                                                if (dv < 5'd16) begin
                                                    n_size = {27'd0, dv};
                                                    cst = ymr_pkg::CV_HEX;
                                                end else cst = ymr_pkg::CV_STOP;
                                            end
                                            ymr_pkg::CV_DEC, ymr_pkg::CV_OCT,
                                            ymr_pkg::CV_HEX: begin
                                                if (cst == ymr_pkg::CV_OCT) base = 5'd8;
                                                else if (cst == ymr_pkg::CV_HEX) base = 5'd16;
                                                if (dv < base) begin
                                                    if (base == 5'd8)
                                                        acc = {1'b0, n_size, 3'd0};
                                                    else if (base == 5'd16)
                                                        acc = {n_size, 4'd0};
                                                    else
                                                        acc = {1'b0, n_size, 3'd0} +
                                                              {3'd0, n_size, 1'b0};
                                                    acc = acc + {31'd0, dv};
                                                    n_size = (acc[35:32] != 4'd0) ?
                                                             32'hffffffff : acc[31:0];
                                                end else begin
                                                    cst = ymr_pkg::CV_STOP;
                                                end
                                            end
                                            default: ;
                                        endcase
                                        n_hf[4:2] = cst;
                                    end
                                end
                            end
                        end
                    end
                    if (r_pos + 11'd1 >= total) begin
                        n_err = '0;
                        n_phase = ymr_pkg::PH_START;
                        if (!n_hf[7]) begin
                            es[cnt] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_NAK,
                                                     '0, '0, '0);
                            cnt = cnt + 2'd1;
                        end else if (!r_taken) begin
                            if (n_hf[5]) begin
                                if (n_size > {8'd0, r_buf_len}) begin
                                    do_cancel = 1'b1;
                                    fin_st = ymr_pkg::ST_TOOLARGE;
                                end else begin
                                    es[0] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_ACK,
                                                           '0, '0, '0);
                                    es[1] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_NAK,
                                                           '0, '0, '0);
                                    cnt = 2'd2;
                                    n_taken = 1'b1;
                                    n_seq = r_seq + 8'd1;
                                end
                            end else begin
                                es[0] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_ACK,
                                                       '0, '0, '0);
                                cnt = 2'd1;
                                do_finish = 1'b1;
                                fin_st = ymr_pkg::ST_DONE;
                                fin_size = n_size;
                            end
                        end else if (wend > {1'b0, r_buf_len}) begin
                            do_cancel = 1'b1;
                            fin_st = ymr_pkg::ST_TOOLARGE;
                        end else begin
                            n_woff = wend[23:0];
                            es[0] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_ACK,
                                                   '0, '0, '0);
                            cnt = 2'd1;
                            n_seq = r_seq + 8'd1;
                        end
                    end else begin
                        n_pos = r_pos + 11'd1;
                    end
                end else begin
                    if (b == ymr_pkg::C_SOH || b == ymr_pkg::C_STX) begin
                        n_phase = ymr_pkg::PH_PACKET;
                        n_long = (b == ymr_pkg::C_STX);
                        n_pos = 11'd1;
                        n_hf = '0;
                        n_ndi = '0;
                    end else if (b == ymr_pkg::C_EOT) begin
                        n_err = '0;
                        es[0] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_ACK,
                                               '0, '0, '0);
                        cnt = 2'd1;
                        n_seq = '0;
                        n_taken = 1'b0;
                        n_woff = '0;
                    end else if (b == ymr_pkg::C_CAN) begin
                        n_phase = ymr_pkg::PH_CAN2;
                    end else begin
                        do_abort = 1'b1;
                    end
                end
            end

            if (do_abort) begin
                n_err = '0;
                es[0] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_ACK, '0, '0, '0);
                cnt = 2'd1;
                do_finish = 1'b1;
                fin_st = ymr_pkg::ST_ABORT;
            end
            if (do_cancel) begin
                es[0] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_CAN, '0, '0, '0);
                es[1] = ymr_pkg::f_res(ymr_pkg::K_REPLY, ymr_pkg::C_CAN, '0, '0, '0);
                cnt = 2'd2;
                do_finish = 1'b1;
            end
            if (do_finish) begin
                es[cnt] = ymr_pkg::f_res(ymr_pkg::K_FINISH, 8'd0, '0, fin_st, fin_size);
                cnt = cnt + 2'd1;
                n_phase = ymr_pkg::PH_IDLE;
            end
            if (cnt != 2'd0) es[cnt - 2'd1].last = 1'b1;
        end
        o_step.cnt = cnt;
        o_step.res = es;
    end

endmodule
`default_nettype wire

@@ rtl/core/ymr_outq.sv @@
`default_nettype none
module ymr_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  ymr_pkg::t_step      i_step,
    output logic                o_room,
    output logic                o_valid,
    input  wire logic           i_ready,
    output ymr_pkg::t_res       o_res
);

    ymr_pkg::t_res r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;

    // Room is signalled only while the queue can take a whole step's worth of items,
    // so no result is lost while the consumer takes results one at a time.
    assign o_room  = (r_cnt <= 3'd1);
    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr  = r_wr + i_step.cnt;
        n_rd  = r_rd + {1'b0, pop};
        n_cnt = r_cnt + {1'b0, i_step.cnt} - {2'd0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < i_step.cnt) r_mem[2'(r_wr + 2'(i))] <= i_step.res[i];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/ymodem_receiver.sv @@
// Each accepted item is processed in the cycle it is accepted; its results
// appear at the output from the next cycle, one per cycle while taken.
// An item is accepted in any cycle the result queue holds at most one item,
// so one item per cycle holds while output is ready and each gives at most one.
// Synchronous active-low reset sets all state but queue storage to defaults.
`default_nettype none
module ymodem_receiver (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_byte_value,
    output logic [23:0]      o_address,
    output logic [2:0]       o_status,
    output logic [31:0]      o_fsize,
    output logic             o_last
);

    ymr_pkg::t_step step;
    ymr_pkg::t_res  res;
    logic           room;

    assign o_in_ready = room;

    ymr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (i_in_valid && room),
        .i_mode      (i_mode),
        .i_rx_byte   (i_rx_byte),
        .o_step      (step)
    );

    ymr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (res)
    );

    assign o_kind       = res.kind;
    assign o_byte_value = res.byte_value;
    assign o_address    = res.address;
    assign o_status     = res.status;
    assign o_fsize      = res.fsize;
    assign o_last       = res.last;

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ymr_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = REG_INIT_TO;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_mode = 1'b0;
    logic [7:0]  in_byte = '0;
    logic        out_ready = 1'b0;
    logic        o_in_ready, o_out_valid, o_last;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte_value;
    logic [23:0] o_address;
    logic [2:0]  o_status;
    logic [31:0] o_fsize;

    ymodem_receiver uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(o_in_ready),
        .i_mode(in_mode), .i_rx_byte(in_byte),
        .o_out_valid(o_out_valid), .i_out_ready(out_ready),
        .o_kind(o_kind), .o_byte_value(o_byte_value), .o_address(o_address),
        .o_status(o_status), .o_fsize(o_fsize), .o_last(o_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct packed {
        logic       m;
        logic [7:0] b;
    } t_item;

    t_item pend_items[$];
    t_res  expected_res[$];
    t_res  step_res[$];

    int  fails = 0, shown = 0, n_in = 0, n_out = 0, idle_cyc = 0;
    int  send_gap = 0, recv_gap = 0, ending = 0;
    bit  quiet = 1'b0, took_item = 1'b0;

    // Receiver state as the block should hold it.
    t_phase      ph = PH_START;
    int          bpos = 0;
    bit          longp = 1'b0, taken = 1'b0, use_retry = 1'b0;
    logic [7:0]  exp_seq = '0, err_cnt = '0, hflags = '0, ndi = '0;
    int unsigned tick_cnt = 0;
    logic [23:0] wr_off = '0;
    logic [31:0] size_val = '0;
    logic [23:0] init_to = 24'hffffff, retry_to = 24'd65535, buf_len = 24'hffffff;
    logic [7:0]  max_err = 8'd5, extra = 8'd30;

    logic [7:0]  body [1024];

    function automatic void emit(logic [1:0] k, logic [7:0] v, logic [23:0] a,
                                 logic [2:0] s, logic [31:0] z);
        if (step_res.size() < MAX_RES) step_res.push_back(f_res(k, v, a, s, z));
    endfunction

    function automatic void finish_session(logic [2:0] s, logic [31:0] z);
        emit(K_FINISH, 8'd0, 24'd0, s, z);
        ph = PH_IDLE;
    endfunction

    function automatic void cancel_session(logic [2:0] s);
        emit(K_REPLY, C_CAN, 24'd0, ST_NONE, 32'd0);
        emit(K_REPLY, C_CAN, 24'd0, ST_NONE, 32'd0);
        finish_session(s, 32'd0);
    endfunction

    function automatic void sender_abort();
        err_cnt = '0;
        emit(K_REPLY, C_ACK, 24'd0, ST_NONE, 32'd0);
        finish_session(ST_ABORT, 32'd0);
    endfunction

    function automatic void count_error();
        int lim;
        lim = (taken ? 0 : int'(extra)) + int'(max_err);
        if (lim > 255) lim = 255;
        if (err_cnt < SAT8) err_cnt++;
        ph = PH_START;
        if (int'(err_cnt) >= lim) begin
            cancel_session(ST_ERRORS);
        end else begin
            if (!taken) use_retry = 1'b1;
            emit(K_REPLY, C_NAK, 24'd0, ST_NONE, 32'd0);
        end
    endfunction

    // strtoul-style size parse, one character at a time.
    function automatic void size_char(logic [7:0] c);
        logic [2:0] st;
        int unsigned dv, base;
        longint unsigned v;
        st = hflags[4:2];
        dv = 16;
        base = 10;
        if (c >= "0" && c <= "9") dv = c - "0";
        else if (c >= "a" && c <= "f") dv = c - "a" + 10;
        else if (c >= "A" && c <= "F") dv = c - "A" + 10;
        case (st)
            CV_START: begin
                if (c == "0") st = CV_ZERO;
                else if (dv >= 1 && dv <= 9) begin
                    size_val = dv;
                    st = CV_DEC;
                end else st = CV_STOP;
            end
            CV_ZERO: begin
                if (c == "x" || c == "X") st = CV_PFX;
                else if (dv < 8) begin
                    size_val = dv;
                    st = CV_OCT;
                end else st = CV_STOP;
            end
            CV_PFX: begin
                if (dv < 16) begin
                    size_val = dv;
                    st = CV_HEX;
                end else st = CV_STOP;
            end
            CV_DEC, CV_OCT, CV_HEX: begin
                if (st == CV_OCT) base = 8;
                else if (st == CV_HEX) base = 16;
                if (dv < base) begin
                    v = longint'(size_val) * base + dv;
                    size_val = (v > 64'hffffffff) ? 32'hffffffff : v[31:0];
                end else st = CV_STOP;
            end
            default: ;
        endcase
        hflags[4:2] = st;
    endfunction

    function automatic void filename_byte(logic [7:0] b, int d);
        int n;
        if (d < 4 && b != 0 && !hflags[5]) begin
            hflags[5] = 1'b1;
            size_val = '0;
            if (hflags[6]) emit(K_NAME, 8'd0, 24'd0, ST_NONE, 32'd0);
        end
        n = ndi;
        if (hflags[1:0] == 2'd0) begin
            if (n >= NAME_LIMIT || b == 0) begin
                if (d == 0 && b == 0) hflags[6] = 1'b1;
                else emit(K_NAME, 8'd0, 24'(n), ST_NONE, 32'd0);
                hflags[1:0] = 2'd1;
                ndi = '0;
            end else begin
                emit(K_NAME, b, 24'(n), ST_NONE, 32'd0);
                ndi = 8'(n + 1);
            end
        end else if (hflags[1:0] == 2'd1) begin
            if (b == C_SPC || n >= SIZE_DIGITS) begin
                hflags[1:0] = 2'd2;
            end else begin
                ndi = 8'(n + 1);
                if (hflags[5]) size_char(b);
            end
        end
    endfunction

    function automatic void close_packet(int unsigned psize);
        err_cnt = '0;
        ph = PH_START;
        if (!hflags[7]) begin
            emit(K_REPLY, C_NAK, 24'd0, ST_NONE, 32'd0);
        end else if (!taken) begin
            if (hflags[5]) begin
                if (size_val > buf_len) begin
                    cancel_session(ST_TOOLARGE);
                end else begin
                    emit(K_REPLY, C_ACK, 24'd0, ST_NONE, 32'd0);
                    emit(K_REPLY, C_NAK, 24'd0, ST_NONE, 32'd0);
                    taken = 1'b1;
                    exp_seq++;
                end
            end else begin
                emit(K_REPLY, C_ACK, 24'd0, ST_NONE, 32'd0);
                finish_session(ST_DONE, size_val);
            end
        end else if (wr_off + psize > buf_len) begin
            cancel_session(ST_TOOLARGE);
        end else begin
            wr_off = 24'(wr_off + psize);
            emit(K_REPLY, C_ACK, 24'd0, ST_NONE, 32'd0);
            exp_seq++;
        end
    endfunction

    function automatic void packet_byte(logic [7:0] b);
        int unsigned psize, idx, d;
        psize = longp ? LONG_DATA : SHORT_DATA;
        idx = bpos;
        if (idx == 1) begin
            if (b == exp_seq) hflags[7] = 1'b1;
        end else if (idx >= HDR_BYTES && idx < HDR_BYTES + psize && hflags[7]) begin
            d = idx - HDR_BYTES;
            if (taken) begin
                if (wr_off + psize <= buf_len)
                    emit(K_WRITE, b, 24'(wr_off + d), ST_NONE, 32'd0);
            end else begin
                filename_byte(b, d);
            end
        end
        if (idx + 1 >= psize + FRAME_OVERHEAD) close_packet(psize);
        else bpos = idx + 1;
    endfunction

    function automatic void start_byte(logic [7:0] b);
        if (b == C_SOH || b == C_STX) begin
            ph = PH_PACKET;
            longp = (b == C_STX);
            bpos = 1;
            hflags = '0;
            ndi = '0;
        end else if (b == C_EOT) begin
            err_cnt = '0;
            emit(K_REPLY, C_ACK, 24'd0, ST_NONE, 32'd0);
            exp_seq = '0;
            taken = 1'b0;
            wr_off = '0;
        end else if (b == C_CAN) begin
            ph = PH_CAN2;
        end else begin
            sender_abort();
        end
    endfunction

    function automatic void predict_item(logic m, logic [7:0] b);
        t_res r;
        step_res.delete();
        if (ph == PH_IDLE) return;
        if (m) begin
            tick_cnt++;
            if (tick_cnt < (use_retry ? retry_to : init_to)) return;
            tick_cnt = 0;
            if (ph == PH_CAN2) sender_abort();
            else count_error();
        end else begin
            tick_cnt = 0;
            if (ph == PH_CAN2) sender_abort();
            else if (ph == PH_PACKET) packet_byte(b);
            else start_byte(b);
        end
        for (int i = 0; i < step_res.size(); i++) begin
            r = step_res[i];
            r.last = (i == step_res.size() - 1);
            expected_res.push_back(r);
        end
    endfunction

    // Sender and receiver pacing; inputs change on the falling edge.
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || took_item) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 4);
                in_valid <= 1'b0;
            end else if (pend_items.size() > 0) begin
                in_valid <= 1'b1;
                in_mode <= pend_items[0].m;
                in_byte <= pend_items[0].b;
                void'(pend_items.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
        if (recv_gap > 0) begin
            recv_gap--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            recv_gap = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_res want;
        bit got_res;
        took_item = 1'b0;
        got_res = 1'b0;
        if (rst_n) begin
            if (in_valid && o_in_ready) begin
                took_item = 1'b1;
                n_in++;
                predict_item(in_mode, in_byte);
            end
            if (o_out_valid && out_ready) begin
                got_res = 1'b1;
                n_out++;
                if (expected_res.size() == 0) begin
                    fails++;
                    if (shown < 10) begin
                        shown++;
                        $display("unexpected result: kind %0d byte %h addr %h status %0d",
                                 o_kind, o_byte_value, o_address, o_status);
                    end
                end else begin
                    want = expected_res.pop_front();
                    if (o_kind !== want.kind || o_byte_value !== want.byte_value ||
                        o_address !== want.address || o_status !== want.status ||
                        o_fsize !== want.fsize || o_last !== want.last) begin
                        fails++;
                        if (shown < 10) begin
                            shown++;
                            $display("mismatch: expected kind %0d byte %h addr %h st %0d size %h last %b",
                                     want.kind, want.byte_value, want.address, want.status,
                                     want.fsize, want.last);
                            $display("          got      kind %0d byte %h addr %h st %0d size %h last %b",
                                     o_kind, o_byte_value, o_address, o_status,
                                     o_fsize, o_last);
                        end
                    end
                end
            end
            if (took_item || got_res || cfg_we) idle_cyc = 0;
            else idle_cyc++;
            if (idle_cyc >= STALL_LIMIT) begin
                $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
                $display("ymodem_receiver regression: fail");
                $finish;
            end
        end
    end

    task automatic put(logic m, logic [7:0] b);
        t_item it;
        it.m = m;
        it.b = b;
        pend_items.push_back(it);
    endtask

    task automatic drain();
        while (pend_items.size() > 0 || in_valid) @(posedge clk);
    endtask

    task automatic settle();
        drain();
        while (expected_res.size() > 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_INIT_TO:  init_to = val;
            REG_RETRY_TO: retry_to = val;
            REG_MAX_ERR:  max_err = val[7:0];
            REG_EXTRA:    extra = val[7:0];
            REG_BUF_LEN:  buf_len = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [23:0] it, logic [23:0] rt, logic [7:0] me,
                            logic [7:0] ex, logic [23:0] bl);
        settle();
        write_reg(REG_INIT_TO, it);
        write_reg(REG_RETRY_TO, rt);
        write_reg(REG_MAX_ERR, {16'd0, me});
        write_reg(REG_EXTRA, {16'd0, ex});
        write_reg(REG_BUF_LEN, bl);
    endtask

    // Ticks just enough for the byte being waited on to time out.
    task automatic tick_out();
        int unsigned lim;
        drain();
        lim = use_retry ? retry_to : init_to;
        for (int unsigned i = tick_cnt; i < lim; i++) put(1'b1, 8'd0);
    endtask

    task automatic send_pkt(bit lp, logic [7:0] seq, int cut);
        int total;
        logic [7:0] b;
        total = (lp ? LONG_DATA : SHORT_DATA) + FRAME_OVERHEAD;
        for (int i = 0; i < total && (cut == 0 || i < cut); i++) begin
            if (i == 0) b = lp ? C_STX : C_SOH;
            else if (i == 1) b = seq;
            else if (i == 2) b = ~seq;
            else if (i < total - 2) b = body[i - HDR_BYTES];
            else b = $urandom_range(0, 255);
            put(1'b0, b);
        end
    endtask

    task automatic random_body();
        for (int i = 0; i < 1024; i++) body[i] = $urandom_range(0, 255);
    endtask

    // Filename packet body: name, a zero, the size text, a space, then filler.
    task automatic make_header(int nlen, string sz);
        random_body();
        for (int i = 0; i < nlen; i++) body[i] = $urandom_range(1, 255);
        body[nlen] = 8'd0;
        for (int k = 0; k < sz.len(); k++) body[nlen + 1 + k] = sz[k];
        body[nlen + 1 + sz.len()] = C_SPC;
    endtask

    function automatic string size_text();
        int unsigned v;
        v = $urandom_range(0, buf_len);
        case ($urandom_range(0, 5))
            0: return $sformatf("%0d", v);
            1: return $sformatf("0x%0h", v);
            2: return $sformatf("0X%0H", v);
            3: return $sformatf("0%0o", v);
            4: return $sformatf("%0dq", v % 1000);
            default: return "z";
        endcase
    endfunction

    function automatic int name_len();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return NAME_LIMIT;
            2: return $urandom_range(0, NAME_LIMIT);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Short timeouts, so that two timeouts cost only three ticks.
        set_regs(24'd1, 24'd2, 8'd255, 8'd255, 24'hffffff);
        tick_out();
        tick_out();

        // One filename packet, then one way of ending the session.
        ending = $urandom_range(0, 4);
        if (ending == 0) begin
            for (int i = 0; i < 1024; i++) body[i] = 8'd0;
        end else if (ending == 3) begin
            make_header(2, "99999999999");
        end else begin
            make_header(name_len(), size_text());
        end
        send_pkt(1'b0, 8'd0, 0);
        drain();

        quiet = 1'b1;
        case (ending)
            1: begin
                put(1'b0, C_CAN);
                put(1'b0, $urandom_range(0, 255));
            end
            2: begin
                set_regs(24'd5, 24'd5, 8'd1, 8'd0, 24'hffffff);
                tick_out();
            end
            4: begin
                random_body();
                send_pkt(1'b0, exp_seq, 6);
                tick_out();
                put(1'b0, 8'h7f);
            end
            default: ;
        endcase
        // The session has ended; these items must be ignored.
        for (int i = 0; i < 4; i++) put($urandom_range(0, 1), $urandom_range(0, 255));

        drain();
        while (expected_res.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("%0d items accepted, %0d results checked, %0d mismatches",
                 n_in, n_out, fails);
        $display("timeouts, one filename packet; session ended by case %0d", ending);
        if (fails == 0) begin
            $display("ymodem_receiver regression: pass");
        end else begin
            $display("ymodem_receiver regression: fail");
        end
        $finish;
    end
endmodule
